// ===== sv/ngh_pkg.sv =====
// ngh_pkg: shared types and constants of the noise gate
// used by the controller, the datapath and the top level
package ngh_pkg;

	localparam int ENV_W      = 23;
	localparam int GAIN_W     = 17;
	localparam int COEFF_W    = 16;
	localparam int HLEN_CFG_W = 18;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'h10000;

	localparam logic [ENV_W-1:0]      OPEN_TH_RST  = 23'd21000;
	localparam logic [ENV_W-1:0]      CLOSE_TH_RST = 23'd10500;
	localparam logic [GAIN_W-1:0]     FLOOR_RST    = 17'd66;
	localparam logic [COEFF_W-1:0]    ATTACK_RST   = 16'd65044;
	localparam logic [COEFF_W-1:0]    RELEASE_RST  = 16'd65531;
	localparam logic [HLEN_CFG_W-1:0] HLEN_RST     = 18'd2880;

	localparam logic [CFG_IDX_W-1:0] REG_OPEN_TH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_TH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 3'd5;

	typedef struct packed {
		logic capture;
		logic mul_gain;
		logic load_prod;
		logic load_gain;
		logic load_out;
	} ngh_cmd_t;

endpackage

// ===== sv/ngh_in_if.sv =====
// ngh_in_if: input channel of the noise gate, sample and envelope
// depends on ngh_pkg for the envelope width
interface ngh_in_if
	import ngh_pkg::*;
#(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic [ENV_W-1:0]              envelope;

	modport source (output valid, output sample, output envelope, input ready);
	modport sink (input valid, input sample, input envelope, output ready);
endinterface

// ===== sv/ngh_out_if.sv =====
// ngh_out_if: result channel of the noise gate
// depends on ngh_pkg for the gain width
interface ngh_out_if
	import ngh_pkg::*;
#(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] gated_sample;
	logic                          gate_open;
	logic [GAIN_W-1:0]             current_gain;

	modport source (output valid, output gated_sample, output gate_open, output current_gain,
		input ready);
	modport sink (input valid, input gated_sample, input gate_open, input current_gain,
		output ready);
endinterface

// ===== sv/ngh_ctrl.sv =====
// ngh_ctrl: sequencer of the noise gate, one item at a time
// drives the datapath commands and the channel handshakes; uses ngh_pkg
module ngh_ctrl
	import ngh_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output ngh_cmd_t cmd
);
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MULG,
		ST_GAIN,
		ST_MULS
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	assign cmd.capture   = in_valid && in_ready;
	assign cmd.mul_gain  = (state_q == ST_MULG);
	assign cmd.load_prod = (state_q == ST_MULG);
	assign cmd.load_gain = (state_q == ST_GAIN);
	assign cmd.load_out  = (state_q == ST_MULS) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_MULG;
				end
				ST_MULG: state_q <= ST_GAIN;
				ST_GAIN: state_q <= ST_MULS;
				ST_MULS: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/ngh_dp.sv =====
// ngh_dp: datapath of the noise gate: registers, gate state, gain smoothing
// one shared multiplier for the smoothing step and the output scaling; uses ngh_pkg
module ngh_dp
	import ngh_pkg::*;
#(
	parameter int SAMPLE_BITS = 24,
	parameter int HOLD_BITS   = 18
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  ngh_cmd_t                      cmd,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	input  logic [ENV_W-1:0]              in_envelope,
	output logic signed [SAMPLE_BITS-1:0] out_sample,
	output logic                          out_open,
	output logic [GAIN_W-1:0]             out_gain
);
	localparam int AW = (SAMPLE_BITS > 18) ? SAMPLE_BITS : 18;
	localparam int PW = AW + 18;
	localparam logic signed [PW-1:0] ROUND_UP = PW'(65535);

	// configuration
	logic [ENV_W-1:0]     open_th_q;
	logic [ENV_W-1:0]     close_th_q;
	logic [GAIN_W-1:0]    floor_q;
	logic [COEFF_W-1:0]   attack_q;
	logic [COEFF_W-1:0]   release_q;
	logic [HOLD_BITS-1:0] hold_len_q;

	// gate state
	logic                 open_q;
	logic [HOLD_BITS-1:0] hold_q;
	logic [GAIN_W-1:0]    gain_q;

	// per item work registers
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic signed [17:0]            diff_q;
	logic [COEFF_W-1:0]            coeff_q;
	logic [GAIN_W-1:0]             target_q;
	logic                          rising_q;
	logic signed [PW-1:0]          prod_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;
	logic                          out_open_q;
	logic [GAIN_W-1:0]             out_gain_q;

	logic                 open_d;
	logic [HOLD_BITS-1:0] hold_d;
	logic [GAIN_W-1:0]    floor_sat;
	logic [GAIN_W-1:0]    target_d;
	logic signed [17:0]   diff_d;
	logic                 rising_d;

	logic signed [AW-1:0] mul_a;
	logic signed [17:0]   mul_b;
	logic signed [PW-1:0] mul_p;
	logic signed [PW-1:0] prod_adj;
	logic signed [PW-1:0] prod_sh;
	logic signed [18:0]   gain_sum;

	// gate decision with hysteresis and hold
	always_comb begin
		open_d = open_q;
		hold_d = hold_q;
		if (!open_q) begin
			if (in_envelope > open_th_q) begin
				open_d = 1'b1;
				hold_d = hold_len_q;
			end
		end else if (in_envelope < close_th_q) begin
			if (hold_q != '0)
				hold_d = hold_q - HOLD_BITS'(1);
			else
				open_d = 1'b0;
		end else begin
			hold_d = hold_len_q;
		end
	end

	assign floor_sat = (floor_q > UNITY_GAIN) ? UNITY_GAIN : floor_q;
	assign target_d  = open_d ? UNITY_GAIN : floor_sat;
	assign rising_d  = target_d > gain_q;
	assign diff_d    = $signed({1'b0, gain_q}) - $signed({1'b0, target_d});

	// shared multiplier
	assign mul_a = cmd.mul_gain ? AW'(diff_q) : AW'(sample_q);
	assign mul_b = cmd.mul_gain ? $signed({2'b00, coeff_q}) : $signed({1'b0, gain_q});
	assign mul_p = PW'(mul_a) * PW'(mul_b);

	// ceil when rising, floor otherwise
	assign prod_adj = rising_q ? (prod_q + ROUND_UP) : prod_q;
	assign prod_sh  = prod_adj >>> 16;
	assign gain_sum = $signed({2'b00, target_q}) + prod_sh[18:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_th_q  <= OPEN_TH_RST;
			close_th_q <= CLOSE_TH_RST;
			floor_q    <= FLOOR_RST;
			attack_q   <= ATTACK_RST;
			release_q  <= RELEASE_RST;
			hold_len_q <= HOLD_BITS'(HLEN_RST);
			open_q     <= 1'b0;
			hold_q     <= '0;
			gain_q     <= UNITY_GAIN;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_OPEN_TH:  open_th_q  <= cfg_data[ENV_W-1:0];
					REG_CLOSE_TH: close_th_q <= cfg_data[ENV_W-1:0];
					REG_FLOOR:    floor_q    <= cfg_data[GAIN_W-1:0];
					REG_ATTACK:   attack_q   <= cfg_data[COEFF_W-1:0];
					REG_RELEASE:  release_q  <= cfg_data[COEFF_W-1:0];
					REG_HOLD:     hold_len_q <= HOLD_BITS'(cfg_data[HLEN_CFG_W-1:0]);
					default: ;
				endcase
			end
			if (cmd.capture) begin
				open_q <= open_d;
				hold_q <= hold_d;
			end
			if (cmd.load_gain)
				gain_q <= gain_sum[GAIN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= in_sample;
			diff_q   <= diff_d;
			coeff_q  <= rising_d ? attack_q : release_q;
			target_q <= target_d;
			rising_q <= rising_d;
		end
		if (cmd.load_prod)
			prod_q <= mul_p;
		if (cmd.load_out) begin
			out_sample_q <= mul_p[SAMPLE_BITS+15:16];
			out_open_q   <= open_q;
			out_gain_q   <= gain_q;
		end
	end

	assign out_sample = out_sample_q;
	assign out_open   = out_open_q;
	assign out_gain   = out_gain_q;
endmodule

// ===== sv/noise_gate_hold_hysteresis_unit.sv =====
// noise_gate_hold_hysteresis_unit: audio noise gate with hold and hysteresis
// depends on ngh_pkg, ngh_in_if, ngh_out_if, ngh_ctrl and ngh_dp
//
// in_ch carries a signed sample and its envelope; out_ch carries the gated
// sample, the gate state after the sample and the smoothed gain. Both use
// valid/ready; a transfer happens at a clock edge with both high.
// cfg_we/cfg_index/cfg_data write one register per edge: 0 open threshold,
// 1 close threshold, 2 floor gain, 3 attack, 4 release, 5 hold length.
// Write only while no item is in flight.
// One item at a time: after an input transfer the block runs the gate
// decision, the smoothing multiply, the gain update and the output multiply
// on one shared multiplier, stepping through the multiply, gain and output
// states, and takes no new input until the result is in the output register.
// The result sits in an output register; if the receiver stalls, the next
// item runs up to its output multiply and waits there until the register
// frees, holding in_ch.ready low meanwhile.
// Reset loads the register defaults, closes the gate, clears the hold
// counter and sets the gain to unity.
module noise_gate_hold_hysteresis_unit
	import ngh_pkg::*;
#(
	parameter int SAMPLE_BITS = 24,
	parameter int HOLD_BITS   = 18
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	ngh_in_if.sink                in_ch,
	ngh_out_if.source             out_ch
);
	ngh_cmd_t cmd;

	ngh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	ngh_dp #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.HOLD_BITS   (HOLD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.in_sample   (in_ch.sample),
		.in_envelope (in_ch.envelope),
		.out_sample  (out_ch.gated_sample),
		.out_open    (out_ch.gate_open),
		.out_gain    (out_ch.current_gain)
	);

`ifndef SYNTHESIS
	a_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.current_gain <= UNITY_GAIN))
		else $error("gain above unity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("input taken while item in flight");

	a_zero_gain_mutes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.current_gain == '0)) |-> (out_ch.gated_sample == '0))
		else $error("nonzero output at zero gain");
`endif
endmodule

// ===== tb/noise_gate_hold_hysteresis_unit_test.sv =====
`timescale 1ns / 1ps
// noise_gate_hold_hysteresis_unit_test: self-checking bench for the noise gate
// depends on ngh_pkg, ngh_in_if, ngh_out_if and noise_gate_hold_hysteresis_unit
// a scoreboard class predicts each result, plain tasks drive the channels and registers
module noise_gate_hold_hysteresis_unit_test;
	import ngh_pkg::*;

	localparam int SW = 24;
	localparam int HB = 18;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam logic [ENV_W-1:0]     ENV_MAX      = '1;
	localparam int                   PHASE_ITEMS  = 210;

	typedef struct packed {
		logic [SW-1:0]     gated;
		logic              opened;
		logic [GAIN_W-1:0] gain;
	} gate_out_t;

	class gain_scoreboard;
		logic [ENV_W-1:0]   open_th;
		logic [ENV_W-1:0]   close_th;
		logic [GAIN_W-1:0]  floor_g;
		logic [COEFF_W-1:0] att_coeff;
		logic [COEFF_W-1:0] rel_coeff;
		logic [HB-1:0]      hold_len;
		logic               is_open;
		logic [HB-1:0]      hold_cnt;
		logic [GAIN_W-1:0]  gain;
		gate_out_t          expected_outs[$];
		int                 errors;
		int                 checked;
		int                 closings;

		function new();
			open_th   = OPEN_TH_RST;
			close_th  = CLOSE_TH_RST;
			floor_g   = FLOOR_RST;
			att_coeff = ATTACK_RST;
			rel_coeff = RELEASE_RST;
			hold_len  = HLEN_RST[HB-1:0];
			is_open   = 1'b0;
			hold_cnt  = '0;
			gain      = UNITY_GAIN;
			errors    = 0;
			checked   = 0;
			closings  = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_OPEN_TH:  open_th = data[ENV_W-1:0];
				REG_CLOSE_TH: close_th = data[ENV_W-1:0];
				REG_FLOOR:    floor_g = data[GAIN_W-1:0];
				REG_ATTACK:   att_coeff = data[COEFF_W-1:0];
				REG_RELEASE:  rel_coeff = data[COEFF_W-1:0];
				REG_HOLD:     hold_len = data[HB-1:0];
				default: ;
			endcase
		endfunction

		function void take_sample(logic signed [SW-1:0] smp, logic [ENV_W-1:0] env);
			logic [GAIN_W-1:0]        target;
			logic [COEFF_W-1:0]       coeff;
			logic                     rising;
			logic [35:0]              acc;
			logic signed [SW+GAIN_W:0] prod;
			gate_out_t                r;
			if (!is_open) begin
				if (env > open_th) begin
					is_open = 1'b1;
					hold_cnt = hold_len;
				end
			end else if (env < close_th) begin
				if (hold_cnt != 0) begin
					hold_cnt = hold_cnt - 1'b1;
				end else begin
					is_open = 1'b0;
					closings++;
				end
			end else begin
				hold_cnt = hold_len;
			end
			if (is_open)
				target = UNITY_GAIN;
			else
				target = (floor_g > UNITY_GAIN) ? UNITY_GAIN : floor_g;
			rising = target > gain;
			coeff = rising ? att_coeff : rel_coeff;
			acc = 36'(coeff) * 36'(gain) + (36'(UNITY_GAIN) - 36'(coeff)) * 36'(target);
			// round up when rising, down otherwise, so the target is always reached
			gain = rising ? GAIN_W'((acc + 36'd65535) >> 16) : GAIN_W'(acc >> 16);
			prod = smp * $signed({1'b0, gain});
			r.gated = SW'(prod >>> 16);
			r.opened = is_open;
			r.gain = gain;
			expected_outs.push_back(r);
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_output(gate_out_t got);
			gate_out_t want;
			checked++;
			if (expected_outs.size() == 0) begin
				report($sformatf("result %0d arrived with nothing expected", checked));
				return;
			end
			want = expected_outs.pop_front();
			if (got.gated !== want.gated)
				report($sformatf("result %0d gated_sample %0d, expected %0d", checked,
					$signed(got.gated), $signed(want.gated)));
			if (got.opened !== want.opened)
				report($sformatf("result %0d gate_open %b, expected %b", checked,
					got.opened, want.opened));
			if (got.gain !== want.gain)
				report($sformatf("result %0d current_gain %0d, expected %0d", checked,
					got.gain, want.gain));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ngh_in_if #(.SAMPLE_BITS(SW)) in_ch ();
	ngh_out_if #(.SAMPLE_BITS(SW)) out_ch ();

	noise_gate_hold_hysteresis_unit #(
		.SAMPLE_BITS(SW),
		.HOLD_BITS(HB)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	gain_scoreboard sb;
	int src_idle_pct;
	int snk_idle_pct;
	bit stall_req;
	int settings;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("noise_gate_hold_hysteresis_unit_test failed");
		$finish;
	end

	// receiver: random back-pressure plus an occasional long hold-off
	initial begin
		int stall_left;
		stall_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready)
				sb.check_output({out_ch.gated_sample, out_ch.gate_open, out_ch.current_gain});
			if (stall_req) begin
				stall_left = 80;
				stall_req = 1'b0;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	task automatic send_item(input logic [SW-1:0] smp, input logic [ENV_W-1:0] env);
		int gap;
		gap = 0;
		while ($urandom_range(99) < src_idle_pct && gap < 20)
			gap++;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample <= smp;
		in_ch.envelope <= env;
		do @(posedge clk); while (!in_ch.ready);
		sb.take_sample(smp, env);
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.expected_outs.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	function automatic logic [COEFF_W-1:0] pick_coeff();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			2: return COEFF_W'($urandom_range(65535, 60000));
			default: return COEFF_W'($urandom);
		endcase
	endfunction

	function automatic logic [SW-1:0] pick_sample();
		case ($urandom_range(24))
			0: return {1'b0, {(SW-1){1'b1}}};
			1: return {1'b1, {(SW-1){1'b0}}};
			2: return '0;
			3: return '1;
			default: return SW'($urandom);
		endcase
	endfunction

	// level classes: quiet, between thresholds, loud, threshold edges, anything
	function automatic logic [ENV_W-1:0] pick_env(input int cls);
		logic [ENV_W-1:0] o;
		logic [ENV_W-1:0] c;
		o = sb.open_th;
		c = sb.close_th;
		case (cls)
			0: return (c == 0) ? '0 : ENV_W'($urandom_range(c - 1, 0));
			1: return ENV_W'($urandom_range(c, o));
			2: return (o == ENV_MAX) ? ENV_MAX : ENV_W'($urandom_range(ENV_MAX, o + 1));
			3: begin
				case ($urandom_range(3))
					0: return o;
					1: return o + 1'b1;
					2: return c;
					default: return c - 1'b1;
				endcase
			end
			default: return ENV_W'($urandom);
		endcase
	endfunction

	task automatic new_settings(input int ph);
		logic [ENV_W-1:0]  o;
		logic [ENV_W-1:0]  c;
		logic [GAIN_W-1:0] f;
		logic [HB-1:0]     h;
		if (ph == 1) begin
			o = '0;
			c = ENV_MAX;
		end else begin
			o = ($urandom_range(9) == 0) ? ENV_W'($urandom) : ENV_W'($urandom_range(40000));
			c = ($urandom_range(4) == 0) ? ENV_W'($urandom_range(2 * o + 10)) : o >> 1;
		end
		f = ($urandom_range(5) == 0) ? GAIN_W'($urandom_range(131071, 65537))
			: GAIN_W'($urandom_range(65536));
		h = (ph == 3) ? '1 : HB'($urandom_range(16));
		write_reg(REG_OPEN_TH, o);
		write_reg(REG_CLOSE_TH, c);
		write_reg(REG_FLOOR, {6'($urandom), f});
		write_reg(REG_ATTACK, {7'($urandom), pick_coeff()});
		write_reg(REG_RELEASE, {7'($urandom), pick_coeff()});
		write_reg(REG_HOLD, {5'($urandom), h});
		settings++;
	endtask

	initial begin
		int n;
		int r;
		int cls;
		int len;
		sb = new();
		settings = 1;
		src_idle_pct = 19;
		snk_idle_pct = 68;
		stall_req = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_OPEN_TH;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.sample <= '0;
		in_ch.envelope <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults, envelope equal to the open threshold keeps the gate shut
		send_item(24'h7FFFFF, '0);
		send_item(24'h000001, 23'd21000);
		wait_idle();

		// zero coefficients, short hold, hold data wider than the register
		write_reg(REG_OPEN_TH, 23'd1000);
		write_reg(REG_CLOSE_TH, 23'd500);
		write_reg(REG_HOLD, 23'h7C0002);
		write_reg(REG_ATTACK, 23'h7F0000);
		write_reg(REG_RELEASE, '0);
		write_reg(REG_FLOOR, '0);
		settings++;
		send_item(24'h123456, 23'd1000);
		send_item(24'h800000, 23'd1001);
		send_item(24'hFFFFFF, 23'd500);
		send_item(24'h7FFFFF, 23'd499);
		send_item(24'h800001, 23'd499);
		send_item(24'h000003, 23'd0);
		send_item(24'hFFFFFD, 23'd0);
		wait_idle();

		// floor above unity
		write_reg(REG_FLOOR, 23'h1FFFF);
		settings++;
		send_item(24'hFFFFFF, 23'd0);
		send_item(24'h800000, 23'd0);
		wait_idle();

		// close threshold above open, no hold, slowest smoothing
		write_reg(REG_OPEN_TH, 23'd100);
		write_reg(REG_CLOSE_TH, 23'd5000);
		write_reg(REG_HOLD, '0);
		write_reg(REG_ATTACK, 23'h00FFFF);
		write_reg(REG_RELEASE, 23'h00FFFF);
		write_reg(REG_FLOOR, '0);
		settings++;
		send_item(24'h7FFFFF, 23'd101);
		send_item(24'h800000, 23'd4999);
		send_item(24'h000005, 23'd5000);
		send_item(24'hFFFFFB, 23'd5000);
		send_item(24'h400000, 23'd100);
		send_item(24'h3FFFFF, 23'd0);
		wait_idle();

		// highest open threshold can never be crossed; spare indexes are ignored
		write_reg(REG_OPEN_TH, ENV_MAX);
		write_reg(REG_CLOSE_TH, '0);
		write_reg(REG_SPARE_LO, 23'h5A5A5);
		write_reg(REG_SPARE_HI, ENV_MAX);
		settings++;
		send_item(24'h7FFFFF, ENV_MAX);
		send_item(24'h000000, 23'd0);

		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			case (ph / 2)
				0: begin
					src_idle_pct = 19;
					snk_idle_pct = 68;
				end
				1: begin
					src_idle_pct = 68;
					snk_idle_pct = 19;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			new_settings(ph);
			if (ph == 4)
				stall_req = 1'b1;
			n = 0;
			while (n < PHASE_ITEMS) begin
				r = $urandom_range(99);
				cls = (r < 35) ? 0 : (r < 65) ? 2 : (r < 75) ? 1 : (r < 85) ? 3 : 4;
				len = $urandom_range(24, 1);
				for (int k = 0; k < len && n < PHASE_ITEMS; k++) begin
					send_item(pick_sample(), pick_env(cls));
					n++;
					if (ph == 5 && n == 100) begin
						wait_idle();
						stall_req = 1'b1;
					end
				end
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		$display("%0d results checked across %0d register settings, gate closed %0d times",
			sb.checked, settings, sb.closings);
		$display("runs included hold expiry, inverted thresholds and long output stalls");
		if (sb.errors == 0) begin
			$display("noise_gate_hold_hysteresis_unit_test passed");
		end else begin
			$display("noise_gate_hold_hysteresis_unit_test failed");
		end
		$finish;
	end

endmodule
